### rtl/gsap_pkg.sv
// ----------------------------------------------------------------------------
// gsap_pkg
// Shared widths, register indexes and types for the gas sensor average and
// forecast block.
// ----------------------------------------------------------------------------
`default_nettype none

package gsap_pkg;

  // window depth and derived widths
  localparam int WINDOW  = 5;
  localparam int ADDR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int AVG_W    = 24;
  localparam int WEIGHT_W = 24;
  localparam int ICPT_W   = 32;
  localparam int DATA_W   = 32;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int DIVD_W  = SUM_W + 8;
  localparam int STEP_W  = $clog2(DIVD_W + 1);
  localparam int PROD_W  = WEIGHT_W + AVG_W + 1;
  localparam int ACC_W   = PROD_W + 1;
  localparam int SHIFT_W = ACC_W - 1 - 16;
  localparam int ENTRY_W = 2 * SAMPLE_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ECO2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TVOC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT   = 2'd2;

  // reset values of the predictor coefficients
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_ECO2_RST = 24'sd43698;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_TVOC_RST = -24'sd251053;
  localparam logic signed [ICPT_W-1:0]   INTERCEPT_RST   = -32'sd16508720;

  // window memory write port
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] data;
  } win_wr_t;

endpackage

`default_nettype wire

### rtl/gsap_window_ram.sv
// ----------------------------------------------------------------------------
// gsap_window_ram
// Sample window storage: one entry per slot holding the eCO2 and TVOC pair,
// one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gsap_window_ram
  import gsap_pkg::*;
(
  input  wire logic               clk,
  input  wire win_wr_t            wr,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [WINDOW];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/gsap_div.sv
// ----------------------------------------------------------------------------
// gsap_div
// Restoring divider, one quotient bit per cycle: scaled window sum divided
// by the number of samples in the window.
// ----------------------------------------------------------------------------
`default_nettype none

module gsap_div
  import gsap_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  sum,
  input  wire logic [CNT_W-1:0]  divisor,
  output logic                   done,
  output logic [AVG_W-1:0]       quotient
);

  logic [DIVD_W-1:0] quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  div_q;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              ge;

  // one restoring step
  always_comb begin
    rem_sh  = {rem, quo[DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, div_q};
    ge      = (rem_sh >= {1'b0, div_q});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= {sum, 8'd0};
      rem   <= '0;
      div_q <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVD_W-2:0], ge};
      rem <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign quotient = quo[AVG_W-1:0];

endmodule

`default_nettype wire

### rtl/gsap_predict.sv
// ----------------------------------------------------------------------------
// gsap_predict
// Linear TVOC predictor: two coefficient products, sum with the scaled
// intercept, then floor to Q16.8 with clamp and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gsap_predict
  import gsap_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic        [AVG_W-1:0]    eco2_avg,
  input  wire logic        [AVG_W-1:0]    tvoc_avg,
  input  wire logic signed [WEIGHT_W-1:0] w_eco2,
  input  wire logic signed [WEIGHT_W-1:0] w_tvoc,
  input  wire logic signed [ICPT_W-1:0]   icpt,
  output logic                            done,
  output logic             [AVG_W-1:0]    forecast
);

  logic signed [PROD_W-1:0] prod_e;
  logic signed [PROD_W-1:0] prod_t;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic [SHIFT_W-1:0]       floored;
  logic [AVG_W-1:0]         forecast_next;
  logic                     v1;
  logic                     v2;

  // sum of products and intercept at 24 fractional bits
  always_comb begin
    acc_next = {{(ACC_W-PROD_W){prod_e[PROD_W-1]}}, prod_e}
             + {{(ACC_W-PROD_W){prod_t[PROD_W-1]}}, prod_t}
             + {{(ACC_W-ICPT_W-8){icpt[ICPT_W-1]}}, icpt, 8'd0};
  end

  // floor to Q16.8, clamp negative to zero, saturate on top
  always_comb begin
    floored = acc[ACC_W-2:16];
    if (acc[ACC_W-1]) begin
      forecast_next = '0;
    end else if (|floored[SHIFT_W-1:AVG_W]) begin
      forecast_next = '1;
    end else begin
      forecast_next = floored[AVG_W-1:0];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  // product, sum and result registers
  always_ff @(posedge clk) begin
    prod_e   <= PROD_W'(w_eco2) * PROD_W'($signed({1'b0, eco2_avg}));
    prod_t   <= PROD_W'(w_tvoc) * PROD_W'($signed({1'b0, tvoc_avg}));
    if (v1) begin
      acc <= acc_next;
    end
    if (v2) begin
      forecast <= forecast_next;
    end
  end

endmodule

`default_nettype wire

### rtl/gas_sensor_average_and_predict.sv
// ----------------------------------------------------------------------------
// gas_sensor_average_and_predict
// Windowed eCO2/TVOC averaging with a linear TVOC forecast.
//
//   channel   signals                                      direction
//   input     in_valid, in_ready, eco2_sample, tvoc_sample   in
//   output    out_valid, out_ready, eco2_average,            out
//             tvoc_average, tvoc_forecast
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data      in
//
// An item passes through these steps in order: one write beat, one memory
// read per stored sample, the registered read, one divider start, the
// divider steps and the done flag, three predictor stages and one output
// load. The divider, at one quotient bit per cycle, is the longest step.
// Reset clears the slot pointer and the fill count and loads the coefficient
// reset values; the window memory needs no clearing since only written entries are read.
// A new beat is taken while a finished result still waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gas_sensor_average_and_predict
  import gsap_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SAMPLE_W-1:0]   eco2_sample,
  input  wire logic [SAMPLE_W-1:0]   tvoc_sample,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [AVG_W-1:0]      eco2_average,
  output logic      [AVG_W-1:0]      tvoc_average,
  output logic      [AVG_W-1:0]      tvoc_forecast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV,
    S_PRED,
    S_OUT
  } state_t;

  state_t state;

  logic signed [WEIGHT_W-1:0] weight_eco2;
  logic signed [WEIGHT_W-1:0] weight_tvoc;
  logic signed [ICPT_W-1:0]   intercept;

  logic [ADDR_W-1:0]  write_slot;
  logic [CNT_W-1:0]   filled_count;
  logic [CNT_W-1:0]   rd_idx;
  logic               rd_pend;
  logic [SUM_W-1:0]   sum_e;
  logic [SUM_W-1:0]   sum_t;

  win_wr_t            wr;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;
  logic               in_beat;
  logic               out_load;
  logic               div_start;
  logic               div_done_e;
  logic               div_done_t;
  logic [AVG_W-1:0]   avg_e;
  logic [AVG_W-1:0]   avg_t;
  logic               pred_start;
  logic               pred_done;
  logic [AVG_W-1:0]   forecast;

  assign in_ready  = !rst && (state == S_IDLE);
  assign cfg_ready = !rst;
  assign in_beat   = in_valid && in_ready;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // sample write into the window
  always_comb begin
    wr.en   = in_beat;
    wr.addr = write_slot;
    wr.data = {eco2_sample, tvoc_sample};
  end

  // sequential read over the filled entries
  assign rd_en      = (state == S_SUM) && (rd_idx < filled_count);
  assign div_start  = (state == S_SUM) && !rd_en && !rd_pend;
  assign pred_start = (state == S_DIV) && div_done_e && div_done_t;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_eco2 <= WEIGHT_ECO2_RST;
      weight_tvoc <= WEIGHT_TVOC_RST;
      intercept   <= INTERCEPT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WEIGHT_ECO2: weight_eco2 <= cfg_data[WEIGHT_W-1:0];
        CFG_WEIGHT_TVOC: weight_tvoc <= cfg_data[WEIGHT_W-1:0];
        CFG_INTERCEPT:   intercept   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, window pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      write_slot   <= '0;
      filled_count <= '0;
      rd_idx       <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            write_slot <= (write_slot == ADDR_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
            if (filled_count != CNT_W'(WINDOW)) begin
              filled_count <= filled_count + 1'b1;
            end
            rd_idx  <= '0;
            rd_pend <= 1'b0;
            state   <= S_SUM;
          end
        end
        S_SUM: begin
          rd_pend <= rd_en;
          if (rd_en) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (pred_start) begin
            state <= S_PRED;
          end
        end
        S_PRED: begin
          if (pred_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            eco2_average  <= avg_e;
            tvoc_average  <= avg_t;
            tvoc_forecast <= forecast;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // window sums, fed by the registered memory read
  always_ff @(posedge clk) begin
    if (in_beat) begin
      sum_e <= '0;
      sum_t <= '0;
    end else if (state == S_SUM && rd_pend) begin
      sum_e <= sum_e + SUM_W'(rd_data[ENTRY_W-1:SAMPLE_W]);
      sum_t <= sum_t + SUM_W'(rd_data[SAMPLE_W-1:0]);
    end
  end

  gsap_window_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  gsap_div u_div_eco2 (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (sum_e),
    .divisor  (filled_count),
    .done     (div_done_e),
    .quotient (avg_e)
  );

  gsap_div u_div_tvoc (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .sum      (sum_t),
    .divisor  (filled_count),
    .done     (div_done_t),
    .quotient (avg_t)
  );

  gsap_predict u_pred (
    .clk      (clk),
    .rst      (rst),
    .start    (pred_start),
    .eco2_avg (avg_e),
    .tvoc_avg (avg_t),
    .w_eco2   (weight_eco2),
    .w_tvoc   (weight_tvoc),
    .icpt     (intercept),
    .done     (pred_done),
    .forecast (forecast)
  );

endmodule

`default_nettype wire

### tb/sv/gas_sensor_average_and_predict_tb.sv
// ----------------------------------------------------------------------------
// gas_sensor_average_and_predict_tb
// Self-checking bench for the windowed eCO2/TVOC averager with TVOC forecast.
// A local copy of the sample windows and of the predictor coefficients works
// out the expected averages and forecast for every accepted sample beat.
// Each output beat is compared field by field with the oldest expected beat.
// The run covers directed first samples, coefficient writes at the extremes,
// a long output hold-off, and random traffic with random idle bursts.
// ----------------------------------------------------------------------------

module gas_sensor_average_and_predict_tb
  import gsap_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  // one expected output beat
  typedef struct packed {
    logic [AVG_W-1:0] eco2_avg;
    logic [AVG_W-1:0] tvoc_avg;
    logic [AVG_W-1:0] forecast;
  } forecast_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SAMPLE_W-1:0]  eco2_sample = '0;
  logic [SAMPLE_W-1:0]  tvoc_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [AVG_W-1:0]     eco2_average;
  logic [AVG_W-1:0]     tvoc_average;
  logic [AVG_W-1:0]     tvoc_forecast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  // predictor copy of the block state
  logic [SAMPLE_W-1:0]        eco2_hist [WINDOW];
  logic [SAMPLE_W-1:0]        tvoc_hist [WINDOW];
  int                         slot_ptr = 0;
  int                         fill_cnt = 0;
  logic signed [WEIGHT_W-1:0] coef_eco2 = WEIGHT_ECO2_RST;
  logic signed [WEIGHT_W-1:0] coef_tvoc = WEIGHT_TVOC_RST;
  logic signed [ICPT_W-1:0]   coef_icpt = INTERCEPT_RST;

  forecast_beat_t pending_forecasts [$];
  int             error_count = 0;
  int             cycle_count = 0;
  bit             sender_idles = 1'b0;
  bit             receiver_idles = 1'b0;
  int             hold_requests = 0;
  int             hold_seen = 0;
  int             hold_len = 0;
  int             ready_gap = 0;

  gas_sensor_average_and_predict u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .eco2_sample   (eco2_sample),
    .tvoc_sample   (tvoc_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .eco2_average  (eco2_average),
    .tvoc_average  (tvoc_average),
    .tvoc_forecast (tvoc_forecast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // output ready: long hold-off on request, else random stall bursts
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      out_ready <= 1'b0;
      hold_len  <= HOLD_CYCLES - 1;
      hold_seen <= hold_requests;
    end else if (hold_len != 0) begin
      out_ready <= 1'b0;
      hold_len  <= hold_len - 1;
    end else if (ready_gap != 0) begin
      out_ready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      ready_gap <= $urandom_range(0, 13);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each output beat with the oldest expected beat
  always @(posedge clk) begin
    forecast_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_forecasts.size() == 0) begin
        $error("unexpected output beat: eco2_average %0d tvoc_average %0d tvoc_forecast %0d",
               eco2_average, tvoc_average, tvoc_forecast);
        error_count++;
      end else begin
        want = pending_forecasts.pop_front();
        if (eco2_average !== want.eco2_avg) begin
          $error("eco2_average: expected %0d, actual %0d", want.eco2_avg, eco2_average);
          error_count++;
        end
        if (tvoc_average !== want.tvoc_avg) begin
          $error("tvoc_average: expected %0d, actual %0d", want.tvoc_avg, tvoc_average);
          error_count++;
        end
        if (tvoc_forecast !== want.forecast) begin
          $error("tvoc_forecast: expected %0d, actual %0d", want.forecast, tvoc_forecast);
          error_count++;
        end
      end
    end
  end

  // window update, averages and clamped forecast for one sample pair
  function automatic void predict_averages(input logic [SAMPLE_W-1:0] eco2,
                                           input logic [SAMPLE_W-1:0] tvoc);
    longint unsigned sum_e;
    longint unsigned sum_t;
    longint          avg_e;
    longint          avg_t;
    longint          acc;
    forecast_beat_t  beat;
    eco2_hist[slot_ptr] = eco2;
    tvoc_hist[slot_ptr] = tvoc;
    slot_ptr = (slot_ptr == WINDOW - 1) ? 0 : slot_ptr + 1;
    if (fill_cnt < WINDOW)
      fill_cnt++;
    sum_e = 0;
    sum_t = 0;
    for (int i = 0; i < fill_cnt; i++) begin
      sum_e += eco2_hist[i];
      sum_t += tvoc_hist[i];
    end
    avg_e = longint'((sum_e << 8) / longint'(fill_cnt));
    avg_t = longint'((sum_t << 8) / longint'(fill_cnt));
    // products carry 24 fraction bits, intercept is Q16.16 so move it up by 8
    acc = longint'(coef_eco2) * avg_e + longint'(coef_tvoc) * avg_t
        + longint'(coef_icpt) * 256;
    beat.eco2_avg = AVG_W'(avg_e);
    beat.tvoc_avg = AVG_W'(avg_t);
    if (acc < 0)
      beat.forecast = '0;
    else if ((acc >>> 16) > longint'({AVG_W{1'b1}}))
      beat.forecast = '1;
    else
      beat.forecast = AVG_W'(acc >>> 16);
    pending_forecasts.push_back(beat);
  endfunction

  // register write as the block sees it; unknown indexes are dropped
  function automatic void apply_coefficient(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] data);
    case (idx)
      CFG_WEIGHT_ECO2: coef_eco2 = data[WEIGHT_W-1:0];
      CFG_WEIGHT_TVOC: coef_tvoc = data[WEIGHT_W-1:0];
      CFG_INTERCEPT:   coef_icpt = data[ICPT_W-1:0];
      default: ;
    endcase
  endfunction

  // one sample beat; valid is left high for a back-to-back follower
  task automatic push_sample(input logic [SAMPLE_W-1:0] eco2,
                             input logic [SAMPLE_W-1:0] tvoc);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    eco2_sample <= eco2;
    tvoc_sample <= tvoc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_averages(eco2, tvoc);
  endtask

  // one register write beat; valid drops only after the last of a group
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] data, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_coefficient(idx, data);
    if (last)
      cfg_valid <= 1'b0;
  endtask

  task automatic load_predictor(input logic [WEIGHT_W-1:0] w_eco2,
                                input logic [WEIGHT_W-1:0] w_tvoc,
                                input logic [ICPT_W-1:0] icpt);
    write_register(CFG_WEIGHT_ECO2, {8'($urandom), w_eco2}, 1'b0);
    write_register(CFG_WEIGHT_TVOC, {8'($urandom), w_tvoc}, 1'b0);
    write_register(CFG_INTERCEPT, icpt, 1'b1);
  endtask

  // stop offering samples and wait until every expected beat is out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_forecasts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(0, 255));
      3:       return {8'hFF, 8'($urandom)};
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // mode 0 keeps the forecast mostly in range, 1 hits the extremes
  function automatic logic [WEIGHT_W-1:0] pick_weight(input int mode);
    case (mode)
      0:       return WEIGHT_W'($urandom_range(0, 8192) - 4096);
      1:       return $urandom_range(0, 1) ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                           : {1'b0, {(WEIGHT_W-1){1'b1}}};
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [ICPT_W-1:0] pick_intercept(input int mode);
    case (mode)
      0:       return ICPT_W'($urandom_range(0, 32'h0400_0000) - 32'h0200_0000);
      1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return ICPT_W'($urandom);
    endcase
  endfunction

  // reset coefficients: first sample, field extremes, window wrap
  task automatic test_first_samples();
    push_sample(16'd0, 16'd0);
    push_sample(16'hFFFF, 16'hFFFF);
    push_sample(16'd0, 16'hFFFF);
    push_sample(16'hFFFF, 16'd0);
    push_sample(16'd1, 16'd1);
    push_sample(16'h8000, 16'h8000);
    push_sample(16'd12345, 16'd54321);
    wait_results_drained();
  endtask

  // saturation, clamp, zero forecast, unit weight and an ignored index
  task automatic test_coefficient_writes();
    load_predictor(24'h7F_FFFF, 24'h7F_FFFF, 32'h7FFF_FFFF);
    push_sample(16'hFFFF, 16'hFFFF);
    push_sample(16'hFFFF, 16'hFFFF);
    wait_results_drained();
    load_predictor(24'h80_0000, 24'h80_0000, 32'h8000_0000);
    push_sample(16'hFFFF, 16'h0000);
    push_sample(16'h0000, 16'hFFFF);
    wait_results_drained();
    load_predictor(24'h00_0000, 24'h00_0000, 32'h0000_0000);
    push_sample(16'h1234, 16'h4321);
    wait_results_drained();
    write_register(CFG_WEIGHT_ECO2, 32'hFF01_0000, 1'b0);
    write_register(CFG_WEIGHT_TVOC, 32'h0000_0000, 1'b0);
    write_register(CFG_INTERCEPT, 32'h0001_0000, 1'b0);
    write_register(CFG_UNUSED_IDX, 32'hFFFF_FFFF, 1'b1);
    push_sample(16'd1000, 16'd2000);
    push_sample(16'd3, 16'd7);
    wait_results_drained();
  endtask

  // output held off while samples keep coming, so the input stalls
  task automatic test_output_holdoff();
    load_predictor(pick_weight(0), pick_weight(0), pick_intercept(0));
    hold_requests <= hold_requests + 1;
    repeat (24) push_sample(pick_sample(), pick_sample());
    wait_results_drained();
  endtask

  // random phases, each with fresh coefficients; no idling at the end
  task automatic test_random_traffic();
    int mode;
    for (int phase = 0; phase < 13; phase++) begin
      mode = $urandom_range(0, 3);
      sender_idles   = (phase < 11) && (phase % 4 != 3);
      receiver_idles = sender_idles;
      if ($urandom_range(0, 3) == 0)
        write_register(CFG_UNUSED_IDX, $urandom, 1'b0);
      load_predictor(pick_weight(mode == 3 ? $urandom_range(0, 2) : mode),
                     pick_weight(mode == 3 ? $urandom_range(0, 2) : mode),
                     pick_intercept(mode == 3 ? $urandom_range(0, 2) : mode));
      repeat (100) push_sample(pick_sample(), pick_sample());
      wait_results_drained();
    end
  endtask

  // main sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_samples();
    test_coefficient_writes();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    test_output_holdoff();
    test_random_traffic();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_forecasts.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
